@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define KAT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define KAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/kat_pkg.sv @@
// Shared types and constants of the two-axis tracker.
`default_nettype none

package kat_pkg;

	localparam int GAIN_BITS = 16;
	localparam int VAR_W     = 26;
	localparam logic [VAR_W-1:0]   VAR_MAX  = {VAR_W{1'b1}};
	localparam logic [GAIN_BITS:0] GAIN_ONE = {1'b1, {GAIN_BITS{1'b0}}};

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_NOISE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y      = 3'd4;

	localparam logic [CFG_W-1:0] RST_PROC_NOISE  = 16'd10;
	localparam logic [CFG_W-1:0] RST_FIRST_NOISE = 16'd10;
	localparam int RST_START_X = 160;
	localparam int RST_START_Y = 120;

	typedef struct packed {
		logic start;
		logic gain;
	} div_req_t;

	typedef struct packed {
		logic rd;
		logic push;
	} hist_ctl_t;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/kat_div.sv @@
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"

module kat_div #(
	parameter int DEN_W = 29,
	parameter int AW    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kat_pkg::div_req_t  req,
	input  logic [DEN_W-1:0]   rem0,
	input  logic [DEN_W-1:0]   den,
	input  logic [AW-1:0]      bits,
	output logic               done,
	output logic [AW-1:0]      quot
);
	import kat_pkg::*;

	localparam int STEP_W = $clog2(AW + 1);
	localparam logic [STEP_W-1:0] GAIN_STEPS = STEP_W'(GAIN_BITS + 1);
	localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(AW);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [AW-1:0]     a_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	assign trial = {rem_q, a_q[AW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= req.gain ? GAIN_STEPS : MEAN_STEPS;
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= rem0;
			den_q <= den;
			a_q   <= bits;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			a_q   <= {a_q[AW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = a_q;

	`KAT_ASSERT_NEXT(a_div_start_busy, req.start, busy_q, "divider did not start")
	`KAT_ASSERT_IMPL(a_div_done_after_busy, done_q, $past(busy_q) && !busy_q,
		"divider done without a running division")

endmodule

`default_nettype wire

@@ rtl/core/kat_hist.sv @@
// Circular history of squared steps for both axes, with fill tracking.
`default_nettype none
`include "assert_macros.svh"

module kat_hist #(
	parameter int WINDOW = 10,
	parameter int WORD_W = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kat_pkg::hist_ctl_t ctl,
	input  logic [WORD_W-1:0]  wdata,
	output logic [WORD_W-1:0]  oldest
);
	import kat_pkg::*;

	localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);

	logic [WORD_W-1:0] mem [WINDOW];
	logic [WORD_W-1:0] rd_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              full;

	assign full = fill_q == FILL_W'(WINDOW);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[ptr_q] <= wdata;
		end
		if (ctl.rd) begin
			rd_q <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (ctl.push) begin
			ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
			if (!full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// Until the window has wrapped, the oldest entry is one of the initial zeros.
	assign oldest = full ? rd_q : '0;

	`KAT_ASSERT_NEXT(a_hist_stays_full, ctl.push && full, full, "history lost its fill")

endmodule

`default_nettype wire

@@ rtl/core/two_axis_kalman_tracker.sv @@
// Top level of the two-axis constant-position Kalman tracker.
//
// Each transfer on the slave side carries one observed position and yields one
// filtered position on the master side. Both axes run a scalar Kalman update in
// turn under one sequencer, sharing one multiplier and one restoring divider that
// yields one quotient bit per cycle. The divider sets the rate; the first item
// after reset needs no noise mean and skips that division. An axis whose gain
// denominator is zero skips the gain division, and a result that cannot leave
// holds the sequencer in its final state until the output register is free.
// The input side is not ready while an item is in work, but a finished result
// waits in the output register while the next item is taken. Configuration writes
// are taken in any cycle and are meant to be issued while the block is idle;
// start positions are taken only until the first item has finished.
`default_nettype none
`include "assert_macros.svh"

module two_axis_kalman_tracker #(
	parameter int WINDOW_LEN = 10,
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [kat_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [kat_pkg::CFG_W-1:0]            wr_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0 up: obs_x, obs_y, zero padding.
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// Fields from bit 0 up: est_x, est_y, zero padding.
	output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata
);
	import kat_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int F      = FRAC_BITS;
	localparam int EW     = CB + F;
	localparam int SQ_W   = 2 * CB;
	localparam int SUM_W  = SQ_W + $clog2(WINDOW_LEN + 1);
	localparam int R_W    = SQ_W + F;
	localparam int AW     = SUM_W + F;
	localparam int DEN_W  = imax(VAR_W, R_W) + 1;
	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int CW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int DATA_W = ((2 * CB + 7) / 8) * 8;
	localparam int PS_W   = imax(VAR_W, CFG_W + F) + 1;
	localparam int MA_W   = imax(VAR_W, imax(GAIN_BITS, CB));
	localparam int MB_W   = imax(EW, imax(GAIN_BITS + 1, CB));
	localparam int MP_W   = MA_W + MB_W;

	localparam logic [CW-1:0]   C_MAX      = CW'(WINDOW_LEN - 1);
	localparam logic [AW-1:0]   GAIN_LIMIT = AW'(GAIN_ONE);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_SQ        = 4'd1;
	localparam logic [3:0] S_SUM       = 4'd2;
	localparam logic [3:0] S_MEAN_GO   = 4'd3;
	localparam logic [3:0] S_MEAN_WAIT = 4'd4;
	localparam logic [3:0] S_GAIN_GO   = 4'd5;
	localparam logic [3:0] S_GAIN_WAIT = 4'd6;
	localparam logic [3:0] S_EST_MUL   = 4'd7;
	localparam logic [3:0] S_EST       = 4'd8;
	localparam logic [3:0] S_VAR_MUL   = 4'd9;
	localparam logic [3:0] S_VAR       = 4'd10;
	localparam logic [3:0] S_FIN       = 4'd11;

	logic [3:0]       state_q;
	logic             ax_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    c_q;

	logic [CFG_W-1:0] qn_q [2];
	logic [CFG_W-1:0] first_q;

	logic [CB-1:0]    obs_q [2];
	logic [CB-1:0]    last_q [2];
	logic [EW-1:0]    est_q [2];
	logic [VAR_W-1:0] var_q [2];
	logic [SUM_W-1:0] sum_q [2];
	logic [SQ_W-1:0]  sq_q [2];

	logic [VAR_W-1:0]     p_q;
	logic [R_W-1:0]       r_q;
	logic [GAIN_BITS-1:0] k_q;
	logic                 dir_q;
	logic [MP_W-1:0]      mul_q;
	logic                 m_tvalid_q;
	logic [DATA_W-1:0]    m_data_q;

	logic                 s_accept;
	logic                 out_free;
	logic [CB-1:0]        obs_a;
	logic [CB-1:0]        last_a;
	logic [EW-1:0]        est_a;
	logic [CB-1:0]        step;
	logic [PS_W-1:0]      psum;
	logic [VAR_W-1:0]     p_next;
	logic [EW-1:0]        target;
	logic                 tgt_ge;
	logic [EW-1:0]        diff;
	logic [EW-1:0]        delta;
	logic [DEN_W-1:0]     den_gain;
	logic [GAIN_BITS:0]   one_minus_k;
	logic [GAIN_BITS-1:0] k_sat;
	logic [MA_W-1:0]      mul_a;
	logic [MB_W-1:0]      mul_b;
	logic [SQ_W-1:0]      old_a;

	div_req_t         div_req;
	logic [DEN_W-1:0] div_rem0;
	logic [DEN_W-1:0] div_den;
	logic [AW-1:0]    div_bits;
	logic             div_done;
	logic [AW-1:0]    div_quot;

	hist_ctl_t         hist_ctl;
	logic [2*SQ_W-1:0] hist_old;

	assign s_tready = state_q == S_IDLE;
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	assign obs_a  = obs_q[ax_q];
	assign last_a = last_q[ax_q];
	assign est_a  = est_q[ax_q];
	assign old_a  = ax_q ? hist_old[2*SQ_W-1:SQ_W] : hist_old[SQ_W-1:0];

	assign step   = (obs_a >= last_a) ? obs_a - last_a : last_a - obs_a;
	assign psum   = PS_W'(var_q[ax_q]) + PS_W'({qn_q[ax_q], {F{1'b0}}});
	assign p_next = (psum > PS_W'(VAR_MAX)) ? VAR_MAX : psum[VAR_W-1:0];

	assign target = {obs_a, {F{1'b0}}};
	assign tgt_ge = target >= est_a;
	assign diff   = tgt_ge ? target - est_a : est_a - target;
	assign delta  = mul_q[GAIN_BITS +: EW];

	assign den_gain    = DEN_W'(p_q) + DEN_W'(r_q);
	assign one_minus_k = GAIN_ONE - {1'b0, k_q};
	assign k_sat       = (|div_quot[AW-1:GAIN_BITS]) ? {GAIN_BITS{1'b1}}
	                                                 : div_quot[GAIN_BITS-1:0];

	always_comb begin
		case (state_q)
			S_SQ: begin
				mul_a = MA_W'(step);
				mul_b = MB_W'(step);
			end
			S_EST_MUL: begin
				mul_a = MA_W'(k_q);
				mul_b = MB_W'(diff);
			end
			S_VAR_MUL: begin
				mul_a = MA_W'(p_q);
				mul_b = MB_W'(one_minus_k);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.gain  = 1'b0;
		div_rem0      = '0;
		div_den       = '0;
		div_bits      = '0;
		case (state_q)
			S_MEAN_GO: begin
				div_req.start = 1'b1;
				div_den       = DEN_W'(c_q) + DEN_W'(1);
				div_bits      = {sum_q[ax_q], {F{1'b0}}};
			end
			S_GAIN_GO: begin
				// The gain quotient is at most one, so only its top bits are worked out.
				div_req.start = den_gain != '0;
				div_req.gain  = 1'b1;
				div_rem0      = DEN_W'(p_q >> 1);
				div_den       = den_gain;
				div_bits      = {p_q[0], {(AW-1){1'b0}}};
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	assign hist_ctl.rd   = s_accept;
	assign hist_ctl.push = (state_q == S_FIN) && out_free && (c_q != '0);

	kat_div #(
		.DEN_W(DEN_W),
		.AW   (AW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rem0  (div_rem0),
		.den   (div_den),
		.bits  (div_bits),
		.done  (div_done),
		.quot  (div_quot)
	);

	kat_hist #(
		.WINDOW(WINDOW_LEN),
		.WORD_W(2 * SQ_W)
	) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (hist_ctl),
		.wdata ({sq_q[1], sq_q[0]}),
		.oldest(hist_old)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ax_q       <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			qn_q[0]    <= RST_PROC_NOISE;
			qn_q[1]    <= RST_PROC_NOISE;
			first_q    <= RST_FIRST_NOISE;
			est_q[0]   <= {CB'(RST_START_X), {F{1'b0}}};
			est_q[1]   <= {CB'(RST_START_Y), {F{1'b0}}};
			var_q[0]   <= '0;
			var_q[1]   <= '0;
			last_q[0]  <= '0;
			last_q[1]  <= '0;
			sum_q[0]   <= '0;
			sum_q[1]   <= '0;
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (wr_en) begin
				case (wr_index)
					CFG_PROC_NOISE_X: qn_q[0] <= wr_data;
					CFG_PROC_NOISE_Y: qn_q[1] <= wr_data;
					CFG_FIRST_NOISE:  first_q <= wr_data;
					CFG_START_X: begin
						if (cnt_q == '0) begin
							est_q[0] <= {wr_data[CB-1:0], {F{1'b0}}};
						end
					end
					CFG_START_Y: begin
						if (cnt_q == '0) begin
							est_q[1] <= {wr_data[CB-1:0], {F{1'b0}}};
						end
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						ax_q    <= 1'b0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (c_q == '0) begin
						state_q <= S_GAIN_GO;
					end else begin
						sum_q[ax_q] <= sum_q[ax_q] - SUM_W'(old_a) + SUM_W'(mul_q[SQ_W-1:0]);
						state_q     <= S_MEAN_GO;
					end
				end
				S_MEAN_GO: begin
					state_q <= S_MEAN_WAIT;
				end
				S_MEAN_WAIT: begin
					if (div_done) begin
						state_q <= S_GAIN_GO;
					end
				end
				S_GAIN_GO: begin
					state_q <= (den_gain == '0) ? S_EST_MUL : S_GAIN_WAIT;
				end
				S_GAIN_WAIT: begin
					if (div_done) begin
						state_q <= S_EST_MUL;
					end
				end
				S_EST_MUL: begin
					state_q <= S_EST;
				end
				S_EST: begin
					est_q[ax_q] <= dir_q ? est_a + delta : est_a - delta;
					state_q     <= S_VAR_MUL;
				end
				S_VAR_MUL: begin
					state_q <= S_VAR;
				end
				S_VAR: begin
					var_q[ax_q]  <= mul_q[GAIN_BITS +: VAR_W];
					last_q[ax_q] <= obs_a;
					if (!ax_q) begin
						ax_q    <= 1'b1;
						state_q <= S_SQ;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						cnt_q   <= CNT_W'(c_q) + CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (s_accept) begin
			obs_q[0] <= s_tdata[CB-1:0];
			obs_q[1] <= s_tdata[2*CB-1:CB];
			c_q      <= (cnt_q >= CNT_W'(C_MAX)) ? C_MAX : cnt_q[CW-1:0];
		end
		case (state_q)
			S_SQ: begin
				p_q <= p_next;
			end
			S_SUM: begin
				sq_q[ax_q] <= mul_q[SQ_W-1:0];
				if (c_q == '0) begin
					r_q <= R_W'({first_q, {F{1'b0}}});
				end
			end
			S_MEAN_WAIT: begin
				if (div_done) begin
					r_q <= div_quot[R_W-1:0];
				end
			end
			S_GAIN_GO: begin
				if (den_gain == '0) begin
					k_q <= '0;
				end
			end
			S_GAIN_WAIT: begin
				if (div_done) begin
					k_q <= k_sat;
				end
			end
			S_EST_MUL: begin
				dir_q <= tgt_ge;
			end
			S_FIN: begin
				if (out_free) begin
					m_data_q <= DATA_W'({est_q[1][EW-1:F], est_q[0][EW-1:F]});
				end
			end
			default: begin
			end
		endcase
	end

	`KAT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
		"input side still ready after taking an item")
	`KAT_ASSERT_IMPL(a_gain_in_range, (state_q == S_GAIN_WAIT) && div_done,
		div_quot <= GAIN_LIMIT, "gain quotient above one")

endmodule

`default_nettype wire
